[design/ptd_pkg.sv]
// Shared constants for the trial-division primality tester.
package ptd_pkg;

  // Which divisor the shared remainder unit is currently working on.
  typedef logic [1:0] phase_t;
  localparam phase_t PhaseThree    = 2'd0;
  localparam phase_t PhaseLow      = 2'd1;
  localparam phase_t PhaseHigh     = 2'd2;

  // Fixed values of the 6k +/- 1 candidate sequence.
  localparam int unsigned LargestSmallPrime = 3;
  localparam int unsigned FirstCandidate    = 5;
  localparam int unsigned CandidateStep     = 6;
  localparam int unsigned PairOffset        = 2;
  localparam int unsigned SquareStepMul     = 12;  // (d+6)^2 - d^2 = 12d + 36
  localparam int unsigned SquareStepAdd     = 36;

endpackage

[design/prime_test_trial_division.sv]
// Top level of the trial-division primality tester with a shared remainder unit.
//
// Usage: drive number_i and raise start. The request is taken at a rising
// clock edge where start is high and busy is low; unless it is answered at
// once, busy stays high until the answer. The answer appears on is_prime_o
// for exactly one clock cycle, marked by valid_o; the receiver must take it
// in that cycle, as there is no way to hold it off. busy is already low in
// that cycle, so a new request may be issued right alongside the answer.
//
// Negative numbers, 0, 1, 2, 3 and even numbers are answered in the cycle
// right after the request is taken, and such requests may come in every
// cycle. Other numbers go through one shared bit-serial remainder unit:
// one remainder by 3, then for every candidate pair d, d + 2
// (d = 5, 11, 17, ...) one bound check and two remainders. The bound d*d is
// kept by addition, so no multiplier is present.
//
// Reset clears the sequencer and the answer strobe; no request is in flight.
module prime_test_trial_division
  import ptd_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [NUM_WIDTH-1:0] number_i,
  output logic                        valid_o,
  output logic                        is_prime_o
);

  // Width of the bit counter that walks the dividend from the top bit down.
  localparam int unsigned CntWidth = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;
  // The running square only ever exceeds the number by less than one step,
  // so two extra bits keep it from wrapping.
  localparam int unsigned SqWidth = NUM_WIDTH + 2;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StBound = 2'd1;
  localparam logic [1:0] StDiv   = 2'd2;

  logic [1:0]           state_q, state_d;
  phase_t               phase_q, phase_d;
  logic [NUM_WIDTH-1:0] value_q, value_d;     // number under test
  logic [NUM_WIDTH-1:0] cand_q, cand_d;       // current d of the 6k - 1 series
  logic [SqWidth-1:0]   square_q, square_d;   // d * d, kept by addition
  logic [NUM_WIDTH-1:0] divisor_q, divisor_d;
  logic [NUM_WIDTH-1:0] rem_q, rem_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 valid_q, valid_d;
  logic                 prime_q, prime_d;

  logic                 accept;
  logic [NUM_WIDTH-1:0] rem_shift;
  logic [NUM_WIDTH-1:0] rem_step;
  logic [SqWidth-1:0]   cand_wide;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  // One restoring division step: bring in the next dividend bit, subtract
  // the divisor if it fits. The remainder stays below the divisor, which is
  // below 2^(NUM_WIDTH-1), so the shifted value fits NUM_WIDTH bits.
  assign rem_shift = {rem_q[NUM_WIDTH-2:0], value_q[cnt_q]};
  assign rem_step  = (rem_shift >= divisor_q) ? (rem_shift - divisor_q) : rem_shift;

  assign cand_wide = SqWidth'(cand_q);

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    value_d   = value_q;
    cand_d    = cand_q;
    square_d  = square_q;
    divisor_d = divisor_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    valid_d   = 1'b0;
    prime_d   = prime_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          value_d = number_i;
          if (number_i[NUM_WIDTH-1] || (number_i <= NUM_WIDTH'(1))) begin
            // Negative numbers, zero and one are not prime.
            valid_d = 1'b1;
            prime_d = 1'b0;
          end else if (number_i <= NUM_WIDTH'(LargestSmallPrime)) begin
            valid_d = 1'b1;
            prime_d = 1'b1;
          end else if (!number_i[0]) begin
            valid_d = 1'b1;
            prime_d = 1'b0;
          end else begin
            // Odd and above three: check divisibility by three first.
            phase_d   = PhaseThree;
            divisor_d = NUM_WIDTH'(LargestSmallPrime);
            rem_d     = '0;
            cnt_d     = CntWidth'(NUM_WIDTH - 1);
            state_d   = StDiv;
          end
        end
      end

      StBound: begin
        if (square_q > SqWidth'(value_q)) begin
          // No candidate up to the square root divides the number.
          valid_d = 1'b1;
          prime_d = 1'b1;
          state_d = StIdle;
        end else begin
          phase_d   = PhaseLow;
          divisor_d = cand_q;
          rem_d     = '0;
          cnt_d     = CntWidth'(NUM_WIDTH - 1);
          state_d   = StDiv;
        end
      end

      StDiv: begin
        rem_d = rem_step;
        cnt_d = cnt_q - CntWidth'(1);
        if (cnt_q == '0) begin
          if (rem_step == '0) begin
            valid_d = 1'b1;
            prime_d = 1'b0;
            state_d = StIdle;
          end else begin
            case (phase_q)
              PhaseThree: begin
                cand_d   = NUM_WIDTH'(FirstCandidate);
                square_d = SqWidth'(FirstCandidate * FirstCandidate);
                state_d  = StBound;
              end
              PhaseLow: begin
                // Try the partner d + 2 of the same pair.
                phase_d   = PhaseHigh;
                divisor_d = cand_q + NUM_WIDTH'(PairOffset);
                rem_d     = '0;
                cnt_d     = CntWidth'(NUM_WIDTH - 1);
              end
              default: begin
                // Advance to the next pair; (d+6)^2 = d^2 + 12d + 36.
                cand_d   = cand_q + NUM_WIDTH'(CandidateStep);
                square_d = square_q + (cand_wide << 3) + (cand_wide << 2)
                           + SqWidth'(SquareStepAdd);
                state_d  = StBound;
              end
            endcase
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    phase_q   <= phase_d;
    value_q   <= value_d;
    cand_q    <= cand_d;
    square_q  <= square_d;
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    prime_q   <= prime_d;
  end

  assign valid_o    = valid_q;
  assign is_prime_o = prime_q;

endmodule

[tb/prime_test_trial_division_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the primality tester: predicts each answer and compares it.
module prime_test_trial_division_checker
  import ptd_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  logic [NUM_WIDTH-1:0] number_i,
  input  logic                 valid_o,
  input  logic                 is_prime_o,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  typedef struct {
    logic [NUM_WIDTH-1:0] number;
    logic                 is_prime;
  } verdict_t;

  verdict_t    verdict_q[$];
  int unsigned n_fail = 0;

  // Trial division by 2, 3 and then the pairs d, d + 2 with d = 5, 11, 17, ...
  function automatic logic predict_is_prime(logic [NUM_WIDTH-1:0] raw);
    longint unsigned v;
    longint unsigned d;
    v = 64'(raw);
    if (raw[NUM_WIDTH-1]) return 1'b0;
    if (v <= 1) return 1'b0;
    if (v <= LargestSmallPrime) return 1'b1;
    if ((v % 2) == 0 || (v % 3) == 0) return 1'b0;
    for (d = FirstCandidate; d * d <= v; d += CandidateStep) begin
      if ((v % d) == 0 || (v % (d + PairOffset)) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    n_fail++;
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      // An answer always belongs to the oldest request, so retire it first.
      if (valid_o) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("answer %b with no request waiting", is_prime_o));
        end else begin
          want = verdict_q.pop_front();
          if (is_prime_o !== want.is_prime) begin
            report_mismatch($sformatf("number %0d: is_prime %b, expected %b",
                                      $signed(want.number), is_prime_o, want.is_prime));
          end
        end
      end
      if (start && !busy) begin
        want.number   = number_i;
        want.is_prime = predict_is_prime(number_i);
        verdict_q.push_back(want);
      end
    end
    fail_count_o <= n_fail;
    pending_o    <= verdict_q.size();
  end

endmodule

[tb/prime_test_trial_division_tb.sv]
`timescale 1ns / 100ps
// Top of the primality tester testbench: clock, reset, request stimulus and verdict.
module prime_test_trial_division_tb;

  localparam int unsigned NumWidth = 32;
  // The slowest correct request, the largest positive prime, goes without
  // any handshake until its answer; the limit leaves ample margin.
  localparam int unsigned IdleCycleLimit = 2_000_000;
  // After the last answer, watch long enough for one more divisor pass.
  localparam int unsigned DrainCycles    = 4 * (NumWidth + 1);
  localparam int unsigned RandomRequests = 100;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [NumWidth-1:0] number_i;
  logic                valid_o;
  logic                is_prime_o;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         idle_cycles = 0;

  // Small primes used to build composites that span the whole positive range
  // but are still rejected after only a few divisor passes.
  int unsigned small_factors[9] = '{5, 7, 11, 13, 17, 19, 23, 29, 31};

  // Corner values: both ends of the range, negatives, zero and one, the two
  // small primes, even numbers, squares where the bound d*d equals the number,
  // a factor caught by the d + 2 divisor, and the largest positive value,
  // which is prime and drives the bound past the top of the signed range.
  logic [NumWidth-1:0] corner_numbers[$] = '{
    32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'd0, 32'd1, 32'd2, 32'd3,
    32'd4, 32'd5, 32'd9, 32'd23, 32'd25, 32'd29, 32'd49, 32'd77, 32'd65537,
    32'd994009, 32'd1022117, 32'h7FFF_FFFD, 32'h7FFF_FFFE, 32'h7FFF_FFFF
  };

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  prime_test_trial_division #(
    .NUM_WIDTH(NumWidth)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .number_i  (number_i),
    .valid_o   (valid_o),
    .is_prime_o(is_prime_o)
  );

  prime_test_trial_division_checker #(
    .NUM_WIDTH(NumWidth)
  ) checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .number_i    (number_i),
    .valid_o     (valid_o),
    .is_prime_o  (is_prime_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Mostly back-to-back or short pauses, with the occasional long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 150);
  endfunction

  // Random numbers are shaped so that the run stays short: full-range values
  // only where the answer comes early (negatives, evens, multiples of small
  // primes), and unrestricted odd values only at small or moderate sizes,
  // since a large prime has to pass every candidate pair up to its root.
  function automatic logic [NumWidth-1:0] pick_number();
    int unsigned roll;
    int unsigned factor;
    roll = $urandom_range(0, 99);
    if (roll < 30) return $urandom_range(0, 4095);
    if (roll < 40) return $urandom_range(4096, 32'h000F_FFFF);
    if (roll < 58) return $urandom | 32'h8000_0000;
    if (roll < 70) return $urandom & 32'hFFFF_FFFE;
    if (roll < 80) return 3 * $urandom_range(0, 32'h7FFF_FFFF / 3);
    factor = small_factors[$urandom_range(0, 8)];
    return factor * $urandom_range(1, 32'h7FFF_FFFF / factor);
  endfunction

  // Presents one request after an optional pause and returns at the edge
  // where it is taken. While paused, the number input carries noise that the
  // block must ignore. With no pause, start simply stays high.
  task automatic send_request(input logic [NumWidth-1:0] value, input int unsigned gap);
    if (gap != 0) begin
      @(negedge clk_i);
      start    <= 1'b0;
      number_i <= $urandom;
      repeat (gap - 1) begin
        @(negedge clk_i);
        number_i <= $urandom;
      end
    end
    @(negedge clk_i);
    start    <= 1'b1;
    number_i <= value;
    do @(posedge clk_i); while (busy);
  endtask

  // Stops issuing requests until every outstanding answer has come back.
  task automatic wait_for_answers();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned gap;
    rst_ni   = 1'b0;
    start    = 1'b0;
    number_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (corner_numbers[i]) send_request(corner_numbers[i], pick_gap());

    for (int i = 0; i < RandomRequests; i++) begin
      // Every 25 requests begin with a burst that has no pauses at all.
      gap = (i % 25 < 8) ? 0 : pick_gap();
      if (i == RandomRequests / 2) wait_for_answers();
      send_request(pick_number(), gap);
    end

    wait_for_answers();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: any accepted request or answer restarts the count.
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleCycleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
